@@ hw/rtl/spa_pkg.sv @@
// Shared types and codes for the sparse polynomial accumulator.
`timescale 1ns / 1ps
`default_nettype none
package spa_pkg;

  // Request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_SAT   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_INS_CHK,
    ST_INS_SH,
    ST_INS_WR,
    ST_DEL,
    ST_DEL_WR,
    ST_RD,
    ST_RD_OUT,
    ST_RESP
  } state_t;

  // Compare / add results of the shared term unit
  typedef struct packed {
    logic gt;    // stored degree above request degree
    logic eq;    // degrees match
    logic sat;   // coefficient sum clipped
    logic zero;  // coefficient sum is zero
  } alu_flags_t;

endpackage
`default_nettype wire

@@ hw/rtl/spa_ifs.sv @@
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface spa_in_if #(
  parameter int COEF_WIDTH   = 32,
  parameter int DEGREE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic signed [COEF_WIDTH-1:0]   term_coef;
  logic signed [DEGREE_WIDTH-1:0] term_degree;

  modport source (output valid, req_type, term_coef, term_degree, input ready);
  modport sink   (input valid, req_type, term_coef, term_degree, output ready);
endinterface

interface spa_out_if #(
  parameter int COEF_WIDTH   = 32,
  parameter int DEGREE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [COEF_WIDTH-1:0]   out_coef;
  logic signed [DEGREE_WIDTH-1:0] out_degree;
  logic [1:0]                     status;
  logic                           last;

  modport source (output valid, out_coef, out_degree, status, last, input ready);
  modport sink   (input valid, out_coef, out_degree, status, last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/spa_term_mem.sv @@
// Term table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module spa_term_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/spa_term_alu.sv @@
// Shared term unit: degree compare and saturating coefficient add.
`timescale 1ns / 1ps
`default_nettype none
module spa_term_alu #(
  parameter int COEF_WIDTH   = 32,
  parameter int DEGREE_WIDTH = 16
) (
  input  wire logic signed [DEGREE_WIDTH-1:0] entry_deg,
  input  wire logic signed [COEF_WIDTH-1:0]   entry_coef,
  input  wire logic signed [DEGREE_WIDTH-1:0] term_deg,
  input  wire logic signed [COEF_WIDTH-1:0]   term_coef,
  output logic signed [COEF_WIDTH-1:0]        sum,
  output spa_pkg::alu_flags_t                 flags
);
  import spa_pkg::*;

  localparam logic [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH:0] wide;
  logic                       ovf;

  assign wide = {entry_coef[COEF_WIDTH-1], entry_coef} + {term_coef[COEF_WIDTH-1], term_coef};
  assign ovf  = wide[COEF_WIDTH] ^ wide[COEF_WIDTH-1];

  // On overflow both operands share a sign; clip toward it.
  always_comb begin
    if (ovf) begin
      sum = entry_coef[COEF_WIDTH-1] ? COEF_MIN : COEF_MAX;
    end else begin
      sum = wide[COEF_WIDTH-1:0];
    end
  end

  assign flags.gt   = entry_deg > term_deg;
  assign flags.eq   = entry_deg == term_deg;
  assign flags.sat  = ovf;
  assign flags.zero = sum == '0;

endmodule
`default_nettype wire

@@ hw/rtl/sparse_polynomial_accumulator_unit.sv @@
// Sparse polynomial accumulator: sequencer around the term table and shared term unit.
//
//  channel   | dir | transfer when  | payload
//  ----------+-----+----------------+----------------------------------------
//  in_chan   | in  | valid & ready  | req_type, term_coef, term_degree
//  out_chan  | out | valid & ready  | out_coef, out_degree, status, last
//
// Each request is taken in ST_IDLE, then: add steps through ST_SRCH and ST_SRCH_CMP
// per entry compared, ST_INS_SH and ST_INS_WR per entry shifted, ST_DEL and ST_DEL_WR
// per entry closed up. Read: ST_RD, ST_RD_OUT per term. Clear: straight to ST_RESP.
// The one-write, one-read table memory with registered read sets the step rate.
// Reset clears the term count; table contents are not cleared.
// in_chan.ready is high only while idle; a stalled result holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sparse_polynomial_accumulator_unit #(
  parameter int MAX_TERMS    = 64,
  parameter int COEF_WIDTH   = 32,
  parameter int DEGREE_WIDTH = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  spa_in_if.sink   in_chan,
  spa_out_if.source out_chan
);
  import spa_pkg::*;

  localparam int IDX_W = $clog2(MAX_TERMS);
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int ENT_W = COEF_WIDTH + DEGREE_WIDTH;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  state_t                         state_r, state_nxt;
  logic [CNT_W-1:0]               idx_r, idx_nxt;
  logic [CNT_W-1:0]               pos_r, pos_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic signed [COEF_WIDTH-1:0]   req_coef_r, req_coef_nxt;
  logic signed [DEGREE_WIDTH-1:0] req_deg_r, req_deg_nxt;
  logic [1:0]                     resp_status_r, resp_status_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic signed [COEF_WIDTH-1:0]   out_coef_r, out_coef_nxt;
  logic signed [DEGREE_WIDTH-1:0] out_deg_r, out_deg_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  logic [ENT_W-1:0]               wr_data;
  logic [IDX_W-1:0]               rd_addr;
  logic [ENT_W-1:0]               rd_data;
  logic signed [DEGREE_WIDTH-1:0] rd_deg;
  logic signed [COEF_WIDTH-1:0]   rd_coef;

  logic signed [COEF_WIDTH-1:0]   alu_sum;
  alu_flags_t                     flags;

  logic                           in_fire;
  logic                           slot_free;
  logic [CNT_W-1:0]               idx_p1;
  logic [CNT_W-1:0]               idx_m1;

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign idx_p1    = idx_r + CNT_ONE;
  assign idx_m1    = idx_r - CNT_ONE;
  assign rd_deg    = rd_data[ENT_W-1:COEF_WIDTH];
  assign rd_coef   = rd_data[COEF_WIDTH-1:0];

  assign in_chan.ready       = state_r == ST_IDLE;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_coef   = out_coef_r;
  assign out_chan.out_degree = out_deg_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.last       = out_last_r;

  spa_term_mem #(
    .DEPTH (MAX_TERMS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spa_term_alu #(
    .COEF_WIDTH   (COEF_WIDTH),
    .DEGREE_WIDTH (DEGREE_WIDTH)
  ) u_alu (
    .entry_deg  (rd_deg),
    .entry_coef (rd_coef),
    .term_deg   (req_deg_r),
    .term_coef  (req_coef_r),
    .sum        (alu_sum),
    .flags      (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_coef_r    <= req_coef_nxt;
    req_deg_r     <= req_deg_nxt;
    resp_status_r <= resp_status_nxt;
    out_coef_r    <= out_coef_nxt;
    out_deg_r     <= out_deg_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    count_nxt       = count_r;
    req_coef_nxt    = req_coef_r;
    req_deg_nxt     = req_deg_r;
    resp_status_nxt = resp_status_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_coef_nxt    = out_coef_r;
    out_deg_nxt     = out_deg_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    wr_addr         = idx_r[IDX_W-1:0];
    wr_data         = {req_deg_r, alu_sum};
    rd_addr         = idx_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_coef_nxt    = in_chan.term_coef;
          req_deg_nxt     = in_chan.term_degree;
          idx_nxt         = '0;
          resp_status_nxt = STAT_OK;
          unique case (in_chan.req_type)
            REQ_ADD: begin
              state_nxt = (in_chan.term_coef == '0) ? ST_RESP : ST_SRCH;
            end
            REQ_READ: begin
              if (count_r == '0) begin
                resp_status_nxt = STAT_EMPTY;
                state_nxt       = ST_RESP;
              end else begin
                state_nxt = ST_RD;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_RESP;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SRCH: begin
        state_nxt = (idx_r == count_r) ? ST_INS_CHK : ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        priority if (flags.gt) begin
          idx_nxt   = idx_p1;
          state_nxt = ST_SRCH;
        end else if (flags.eq) begin
          resp_status_nxt = flags.sat ? STAT_SAT : STAT_OK;
          if (flags.zero) begin
            state_nxt = ST_DEL;
          end else begin
            wr_en     = 1'b1;
            state_nxt = ST_RESP;
          end
        end else begin
          state_nxt = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        if (count_r == CNT_MAX) begin
          resp_status_nxt = STAT_FULL;
          state_nxt       = ST_RESP;
        end else begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r;
          state_nxt = ST_INS_SH;
        end
      end
      // Open a hole at pos_r by moving entries up from the tail.
      ST_INS_SH: begin
        if (idx_r == pos_r) begin
          wr_en     = 1'b1;
          wr_data   = {req_deg_r, req_coef_r};
          count_nxt = count_r + CNT_ONE;
          state_nxt = ST_RESP;
        end else begin
          rd_addr   = idx_m1[IDX_W-1:0];
          state_nxt = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data;
        idx_nxt   = idx_m1;
        state_nxt = ST_INS_SH;
      end
      // Close the gap left by a cancelled term.
      ST_DEL: begin
        if (idx_p1 >= count_r) begin
          count_nxt = count_r - CNT_ONE;
          state_nxt = ST_RESP;
        end else begin
          rd_addr   = idx_p1[IDX_W-1:0];
          state_nxt = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data;
        idx_nxt   = idx_p1;
        state_nxt = ST_DEL;
      end
      ST_RD: begin
        state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_coef_nxt   = rd_coef;
          out_deg_nxt    = rd_deg;
          out_status_nxt = STAT_OK;
          out_last_nxt   = idx_p1 == count_r;
          idx_nxt        = idx_p1;
          state_nxt      = (idx_p1 == count_r) ? ST_IDLE : ST_RD;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_coef_nxt   = '0;
          out_deg_nxt    = '0;
          out_status_nxt = resp_status_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("term count above table size");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_SH) |-> (count_r < CNT_MAX) && (pos_r <= idx_r))
    else $error("insert shift without room");

  a_delete_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL) |-> (count_r != '0) && (idx_r < count_r))
    else $error("delete outside valid terms");

  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.req_type == REQ_ADD || in_chan.req_type == REQ_READ
                 || in_chan.req_type == REQ_CLEAR)) |=> (state_r != ST_IDLE))
    else $error("accepted request did not start");

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the sparse polynomial accumulator: term merge, read-out, clear.
`timescale 1ns / 1ps
module testbench;
  import spa_pkg::*;

  localparam int NUM_TERMS   = 64;
  localparam int CW          = 32;
  localparam int DW          = 16;
  localparam int STALL_LIMIT = 3000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES = 200;   // idle tail before the final check
  localparam int MAX_PRINTS  = 100;

  localparam logic [1:0] REQ_NONE = 2'd3;  // unused selector, block drops it
  localparam logic signed [CW-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] COEF_MIN = 32'sh8000_0000;

  typedef struct {
    logic [1:0]           req_type;
    logic signed [CW-1:0] coef;
    logic signed [DW-1:0] degree;
  } poly_req_t;

  typedef struct {
    logic signed [CW-1:0] coef;
    logic signed [DW-1:0] degree;
    logic [1:0]           status;
    logic                 last;
  } term_result_t;

  logic clk;
  logic rst_n;

  spa_in_if  #(.COEF_WIDTH(CW), .DEGREE_WIDTH(DW)) in_chan ();
  spa_out_if #(.COEF_WIDTH(CW), .DEGREE_WIDTH(DW)) out_chan ();

  sparse_polynomial_accumulator_unit #(
    .MAX_TERMS(NUM_TERMS),
    .COEF_WIDTH(CW),
    .DEGREE_WIDTH(DW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  poly_req_t    pending_reqs[$];
  term_result_t expected_results[$];

  // Predicted polynomial, descending degree, no zero coefficients
  logic signed [DW-1:0] poly_deg[NUM_TERMS];
  logic signed [CW-1:0] poly_coef[NUM_TERMS];
  int poly_len;

  int items_queued;
  int items_accepted;
  int mismatches;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  logic in_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_result(input logic signed [CW-1:0] c, input logic signed [DW-1:0] d,
                             input logic [1:0] st, input logic lst);
    term_result_t t;
    t.coef   = c;
    t.degree = d;
    t.status = st;
    t.last   = lst;
    expected_results.push_back(t);
  endtask

  // Merge one accepted request into the predicted polynomial and queue its results.
  task automatic merge_request(input poly_req_t r);
    int pos;
    int k;
    logic signed [CW:0] sum;
    logic [1:0] st;
    case (r.req_type)
      REQ_ADD: begin
        st = STAT_OK;
        if (r.coef != 0) begin
          pos = 0;
          while (pos < poly_len && poly_deg[pos] > r.degree) pos++;
          if (pos < poly_len && poly_deg[pos] == r.degree) begin
            sum = poly_coef[pos] + r.coef;
            if (sum[CW] != sum[CW-1]) begin
              st = STAT_SAT;
              poly_coef[pos] = sum[CW] ? COEF_MIN : COEF_MAX;
            end else if (sum == 0) begin
              // coefficients cancel: close the gap
              for (k = pos; k + 1 < poly_len; k++) begin
                poly_deg[k]  = poly_deg[k + 1];
                poly_coef[k] = poly_coef[k + 1];
              end
              poly_len--;
            end else begin
              poly_coef[pos] = sum[CW-1:0];
            end
          end else if (poly_len >= NUM_TERMS) begin
            st = STAT_FULL;
          end else begin
            for (k = poly_len; k > pos; k--) begin
              poly_deg[k]  = poly_deg[k - 1];
              poly_coef[k] = poly_coef[k - 1];
            end
            poly_deg[pos]  = r.degree;
            poly_coef[pos] = r.coef;
            poly_len++;
          end
        end
        push_result('0, '0, st, 1'b1);
      end
      REQ_READ: begin
        if (poly_len == 0) push_result('0, '0, STAT_EMPTY, 1'b1);
        for (k = 0; k < poly_len; k++)
          push_result(poly_coef[k], poly_deg[k], STAT_OK, k + 1 == poly_len);
      end
      REQ_CLEAR: begin
        poly_len = 0;
        push_result('0, '0, STAT_OK, 1'b1);
      end
      default: ;
    endcase
  endtask

  // Driver: inputs change on the falling edge
  always @(negedge clk) begin : drive
    poly_req_t r;
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      out_chan.ready <= 1'b0;
    end else begin
      if (!in_chan.valid || in_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.req_type    <= r.req_type;
          in_chan.term_coef   <= r.coef;
          in_chan.term_degree <= r.degree;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: transfers sampled on the rising edge
  always @(posedge clk) begin : monitor
    poly_req_t r;
    term_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        r.req_type = in_chan.req_type;
        r.coef     = in_chan.term_coef;
        r.degree   = in_chan.term_degree;
        merge_request(r);
        items_accepted++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, status", out_chan.status, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_chan.out_coef !== want.coef)
            report_mismatch("out_coef", out_chan.out_coef, want.coef);
          if (out_chan.out_degree !== want.degree)
            report_mismatch("out_degree", out_chan.out_degree, want.degree);
          if (out_chan.status !== want.status)
            report_mismatch("status", out_chan.status, want.status);
          if (out_chan.last !== want.last)
            report_mismatch("last", out_chan.last, want.last);
        end
      end
    end
  end

  // Watchdog on stretches with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("sparse_polynomial_accumulator_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(input logic [1:0] rt, input logic signed [CW-1:0] c,
                           input logic signed [DW-1:0] d);
    poly_req_t r;
    r.req_type = rt;
    r.coef     = c;
    r.degree   = d;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  function automatic logic signed [CW-1:0] rand_coef();
    logic signed [CW-1:0] c;
    case ($urandom_range(0, 5))
      0: begin
        c = $urandom_range(0, 40);
        c = c - 20;
      end
      1, 2: c = $urandom;
      3: c = COEF_MAX - $urandom_range(0, 3);
      4: c = COEF_MIN + $urandom_range(0, 3);
      default: c = $urandom_range(0, 1) ? 1 : -1;
    endcase
    return c;
  endfunction

  // Mostly a narrow degree pool so that terms collide and cancel
  function automatic logic signed [DW-1:0] rand_degree();
    logic signed [DW-1:0] d;
    if ($urandom_range(0, 3) == 0) begin
      d = DW'($urandom);
    end else begin
      d = DW'($urandom_range(0, 12));
      d = d - 16'sd6;
    end
    return d;
  endfunction

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Clear, fill all entries with distinct degrees, merge while full, overflow, read back, clear.
  task automatic fill_table();
    logic signed [DW-1:0] base;
    logic signed [CW-1:0] c;
    int i;
    base = DW'($urandom);
    queue_req(REQ_CLEAR, $urandom, DW'($urandom));
    for (i = 0; i < NUM_TERMS; i++) begin
      c = rand_coef();
      if (c == 0) c = 1;
      queue_req(REQ_ADD, c, base + DW'(977 * i));
    end
    queue_req(REQ_ADD, rand_coef(), base);                     // merge while full
    queue_req(REQ_ADD, 32'sd5, base + DW'(977 * NUM_TERMS));   // dropped
    queue_req(REQ_ADD, $urandom | 1, DW'($urandom));
    queue_req(REQ_READ, '0, '0);
    queue_req(REQ_CLEAR, '0, '0);
  endtask

  task automatic random_phase(input int n_items);
    logic signed [CW-1:0] c;
    logic signed [DW-1:0] d;
    int start;
    int n;
    int i;
    int pick;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        n = $urandom_range(2, 8);
        for (i = 0; i < n; i++) begin
          c = rand_coef();
          d = rand_degree();
          queue_req(REQ_ADD, c, d);
          if ($urandom_range(0, 3) == 0) queue_req(REQ_ADD, -c, d);
        end
        if ($urandom_range(0, 4) != 0) queue_req(REQ_READ, $urandom, DW'($urandom));
      end else if (pick < 82) begin
        queue_req(REQ_CLEAR, $urandom, DW'($urandom));
      end else if (pick < 90) begin
        queue_req(REQ_NONE, $urandom, DW'($urandom));
      end else if (pick < 95) begin
        queue_req(REQ_ADD, '0, DW'($urandom));
      end else begin
        queue_req(REQ_READ, $urandom, DW'($urandom));
      end
    end
  endtask

  initial begin
    int p;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.req_type     = REQ_ADD;
    in_chan.term_coef    = '0;
    in_chan.term_degree  = '0;
    out_chan.ready       = 1'b0;
    in_taken             = 1'b0;
    poly_len             = 0;
    items_queued         = 0;
    items_accepted       = 0;
    mismatches           = 0;
    quiet_cycles         = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;

    // directed: empty read, ignored zero term, extremes, saturation both ways,
    // cancellation, ordered insert, unused selector, clear
    queue_req(REQ_READ, '0, '0);
    queue_req(REQ_ADD, '0, 16'sd5);
    queue_req(REQ_ADD, COEF_MAX, 16'sh7FFF);
    queue_req(REQ_ADD, COEF_MIN, 16'sh8000);
    queue_req(REQ_ADD, 32'sd1, 16'sh7FFF);
    queue_req(REQ_ADD, -32'sd1, 16'sh8000);
    queue_req(REQ_ADD, 32'sd7, 16'sd3);
    queue_req(REQ_ADD, -32'sd7, 16'sd3);
    queue_req(REQ_ADD, 32'sd5, 16'sd0);
    queue_req(REQ_ADD, 32'sd9, -16'sd1);
    queue_req(REQ_ADD, 32'sd3, 16'sd1);
    queue_req(REQ_READ, '0, '0);
    queue_req(REQ_NONE, COEF_MAX, 16'sh7FFF);
    queue_req(REQ_ADD, COEF_MIN, 16'sh7FFF);
    queue_req(REQ_ADD, 32'sd1, 16'sh7FFF);
    queue_req(REQ_ADD, COEF_MIN, 16'sh8000);
    queue_req(REQ_READ, '0, '0);
    queue_req(REQ_CLEAR, '0, '0);
    queue_req(REQ_READ, '0, '0);
    queue_req(REQ_CLEAR, 32'shFFFF_FFFF, 16'shFFFF);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    for (p = 0; p < 4; p++) begin
      // idle pattern per phase: none, sender, receiver, both
      send_idle_pct  <= (p == 1) ? 48 : (p == 3) ? 25 : 0;
      recv_stall_pct <= (p == 2) ? 48 : (p == 3) ? 25 : 0;
      @(posedge clk);
      if (p == 1) fill_table();
      random_phase(60);
      wait_drained();  // sender holds off until every result is back
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("sparse_polynomial_accumulator_unit regression: pass");
    else
      $display("sparse_polynomial_accumulator_unit regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/spa_pkg.sv
hw/rtl/spa_ifs.sv
hw/rtl/spa_term_mem.sv
hw/rtl/spa_term_alu.sv
hw/rtl/sparse_polynomial_accumulator_unit.sv
bench/testbench.sv
